// ===== rtl/fia_pkg.sv =====
package fia_pkg;

  localparam int ENTRY_W  = 11;
  localparam int CNT_W    = 11;
  localparam int STRIDE_W = 16;
  localparam int PROD_W   = ENTRY_W + STRIDE_W;
  localparam int ADDR_W   = 64;
  localparam int IDX_W    = 16;
  localparam int SLOT_W   = 10;
  localparam int CFG_IDX_W = 8;

  localparam logic [2:0] OP_INIT       = 3'd0;
  localparam logic [2:0] OP_ALLOCATE   = 3'd1;
  localparam logic [2:0] OP_FREE       = 3'd2;
  localparam logic [2:0] OP_CPU_LOOKUP = 3'd3;
  localparam logic [2:0] OP_GPU_LOOKUP = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_STRIDE  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CPU_BASE     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GPU_BASE     = 8'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_KIND    = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WANT_VISIBLE = 8'd5;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_NOT_INIT  = 3'd1,
    STS_FULL      = 3'd2,
    STS_BAD_INDEX = 3'd3,
    STS_BAD_CAP   = 3'd4,
    STS_OVERFREE  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    K_INIT,
    K_ALLOC,
    K_FREE,
    K_LOOKUP,
    K_NOP
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_MUL,
    ST_ADD
  } state_t;

  typedef struct packed {
    kind_t            kind;
    logic [IDX_W-1:0] idx;
    logic             hvalid;
    logic             idx_ok;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0]    capacity;
    logic [STRIDE_W-1:0] slot_stride;
    logic [ADDR_W-1:0]   cpu_base;
    logic [ADDR_W-1:0]   gpu_base;
    logic [1:0]          heap_kind;
    logic                want_visible;
  } cfg_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] cpu_addr;
    logic [ADDR_W-1:0] gpu_addr;
    logic [CNT_W-1:0]  in_use;
  } res_t;

  typedef struct packed {
    logic             filling;
    logic [CNT_W-1:0] free_cnt;
  } stat_t;

endpackage

// ===== rtl/fifo_index_allocator_core.sv =====
// Slot allocator with a first-in first-out free list. Items enter through a
// two-beat command queue and results leave through a two-beat result queue.
// Free, init with nothing to do, every refused request and unused op codes
// complete in the idle state of the execution unit; allocate goes on through
// a ring read at the head pointer, the slot times stride multiply and the base
// add, lookups through the multiply and the add; a successful init walks the
// ring memory writing slots 0 to capacity-1, one entry a cycle. Commands pass
// through the registered command queue first. Configuration writes are always
// ready and must only be made while no item is in flight.
module fifo_index_allocator_core
  import fia_pkg::*;
#(
  parameter int MAX_SLOTS = 1024
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [2:0]           in_op,
  input  logic [IDX_W-1:0]     in_slot_index,
  input  logic                 in_handle_valid,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [2:0]           out_status,
  output logic [SLOT_W-1:0]    out_slot_out,
  output logic [ADDR_W-1:0]    out_cpu_addr,
  output logic [ADDR_W-1:0]    out_gpu_addr,
  output logic [CNT_W-1:0]     out_in_use,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  cfg_t  cfg_r;
  logic  cmd_valid;
  logic  cmd_take;
  cmd_t  cmd;
  res_t  res;
  stat_t stat;
  logic  cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.capacity     <= '0;
      cfg_r.slot_stride  <= 16'd32;
      cfg_r.cpu_base     <= '0;
      cfg_r.gpu_base     <= '0;
      cfg_r.heap_kind    <= '0;
      cfg_r.want_visible <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_CAPACITY:     cfg_r.capacity     <= cfg_data[CNT_W-1:0];
        CFG_SLOT_STRIDE:  cfg_r.slot_stride  <= cfg_data[STRIDE_W-1:0];
        CFG_CPU_BASE:     cfg_r.cpu_base     <= cfg_data;
        CFG_GPU_BASE:     cfg_r.gpu_base     <= cfg_data;
        CFG_HEAP_KIND:    cfg_r.heap_kind    <= cfg_data[1:0];
        CFG_WANT_VISIBLE: cfg_r.want_visible <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  fia_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_op           (in_op),
    .in_slot_index   (in_slot_index),
    .in_handle_valid (in_handle_valid),
    .capacity        (cfg_r.capacity),
    .cmd_valid       (cmd_valid),
    .cmd_take        (cmd_take),
    .cmd             (cmd)
  );

  fia_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (res),
    .stat      (stat)
  );

  assign out_status   = res.status;
  assign out_slot_out = res.slot;
  assign out_cpu_addr = res.cpu_addr;
  assign out_gpu_addr = res.gpu_addr;
  assign out_in_use   = res.in_use;

`ifndef SYNTHESIS
  a_fill_holds_queue: assert property (@(posedge clk) disable iff (!rst_n)
    stat.filling |-> !cmd_take)
    else $error("command taken during ring fill");

  a_free_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    {6'd0, stat.free_cnt} <= 17'(MAX_SLOTS))
    else $error("free count above ring depth");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full && !stat.filling))
    else $error("queues not clear after reset");
`endif

endmodule

// ===== rtl/fia_front.sv =====
module fia_front
  import fia_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic [2:0]       in_op,
  input  logic [IDX_W-1:0] in_slot_index,
  input  logic             in_handle_valid,
  input  logic [CNT_W-1:0] capacity,
  output logic             cmd_valid,
  input  logic             cmd_take,
  output cmd_t             cmd
);

  cmd_t       q_mem [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic       acc;
  logic       take;
  cmd_t       dec;

  always_comb begin
    dec.idx    = in_slot_index;
    dec.hvalid = in_handle_valid;
    dec.idx_ok = {{(IDX_W-CNT_W){1'b0}}, capacity} > in_slot_index;
    unique case (in_op)
      OP_INIT:       dec.kind = K_INIT;
      OP_ALLOCATE:   dec.kind = K_ALLOC;
      OP_FREE:       dec.kind = K_FREE;
      OP_CPU_LOOKUP: dec.kind = K_LOOKUP;
      OP_GPU_LOOKUP: dec.kind = K_LOOKUP;
      default:       dec.kind = K_NOP;
    endcase
  end

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_mem[rp_r];
  assign acc       = in_push && !in_full;
  assign take      = cmd_take && cmd_valid;

  always_comb begin
    wp_nxt  = acc  ? ~wp_r : wp_r;
    rp_nxt  = take ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, acc} - {1'b0, take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      q_mem[wp_r] <= dec;
    end
  end

endmodule

// ===== rtl/fia_back.sv =====
module fia_back
  import fia_pkg::*;
#(
  parameter int MAX_SLOTS = 1024
)
(
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic cmd_valid,
  output logic cmd_take,
  input  cmd_t cmd,
  output logic out_empty,
  input  logic out_pop,
  output res_t out_res,
  output stat_t stat
);

  localparam int PTR_W = $clog2(MAX_SLOTS);
  localparam logic [16:0] MAX_W17 = 17'(MAX_SLOTS);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_SLOTS - 1);

  logic [ENTRY_W-1:0] ring_mem [0:MAX_SLOTS-1];
  logic [ENTRY_W-1:0] ring_rdata_r;
  logic               ring_we;
  logic [PTR_W-1:0]   ring_waddr;
  logic [ENTRY_W-1:0] ring_wdata;

  state_t             state_r, state_nxt;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   free_r, free_nxt;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic               ready_r, ready_nxt;
  logic               vis_r, vis_nxt;
  logic [PTR_W-1:0]   fill_r, fill_nxt;
  logic [ENTRY_W-1:0] slot_r, slot_nxt;
  logic               look_r, look_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [ENTRY_W-1:0] mul_in;

  res_t       q_mem [2];
  logic [1:0] q_cnt_r;
  logic       q_wp_r, q_rp_r;
  logic       q_full;
  logic       push;
  res_t       push_res;
  logic       pop;

  logic cap_zero, cap_big, cap_full, free_over, fill_last;

  assign q_full    = (q_cnt_r == 2'd2);
  assign out_empty = (q_cnt_r == 2'd0);
  assign out_res   = q_mem[q_rp_r];
  assign pop       = out_pop && !out_empty;

  assign cap_zero  = (cfg.capacity == '0);
  assign cap_big   = {6'd0, cfg.capacity} > MAX_W17;
  assign cap_full  = {6'd0, cfg.capacity} >= MAX_W17;
  assign free_over = (free_r >= cfg.capacity) || ({6'd0, free_r} >= MAX_W17);
  assign fill_last = (17'(fill_r) == ({6'd0, cfg.capacity} - 17'd1));

  assign stat.filling  = (state_r == ST_FILL);
  assign stat.free_cnt = free_r;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    free_nxt  = free_r;
    used_nxt  = used_r;
    ready_nxt = ready_r;
    vis_nxt   = vis_r;
    fill_nxt  = fill_r;
    slot_nxt  = slot_r;
    look_nxt  = look_r;
    prod_nxt  = prod_r;
    cmd_take  = 1'b0;
    push      = 1'b0;
    push_res.status   = STS_OK;
    push_res.slot     = '0;
    push_res.cpu_addr = '0;
    push_res.gpu_addr = '0;
    push_res.in_use   = used_r;
    ring_we    = 1'b0;
    ring_waddr = tail_r;
    ring_wdata = cmd.idx[ENTRY_W-1:0];
    mul_in     = look_r ? slot_r : ring_rdata_r;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid && !q_full) begin
          cmd_take = 1'b1;
          unique case (cmd.kind)
            K_INIT: begin
              priority if (ready_r) begin
                push = 1'b1;
              end else if (cap_zero || cap_big) begin
                push = 1'b1;
                push_res.status = STS_BAD_CAP;
              end else begin
                vis_nxt   = cfg.want_visible && !cfg.heap_kind[1];
                head_nxt  = '0;
                tail_nxt  = cap_full ? '0 : PTR_W'(cfg.capacity);
                free_nxt  = cfg.capacity;
                used_nxt  = '0;
                ready_nxt = 1'b1;
                fill_nxt  = '0;
                state_nxt = ST_FILL;
              end
            end
            K_ALLOC: begin
              priority if (!ready_r) begin
                push = 1'b1;
                push_res.status = STS_NOT_INIT;
              end else if (free_r == '0) begin
                push = 1'b1;
                push_res.status = STS_FULL;
              end else begin
                head_nxt  = ptr_next(head_r);
                free_nxt  = free_r - 1'b1;
                used_nxt  = used_r + 1'b1;
                look_nxt  = 1'b0;
                state_nxt = ST_MUL;
              end
            end
            K_FREE: begin
              push = 1'b1;
              push_res.slot = cmd.idx[SLOT_W-1:0];
              priority if (!ready_r) begin
                push_res.status = STS_NOT_INIT;
              end else if (!cmd.hvalid || !cmd.idx_ok) begin
                push_res.status = STS_BAD_INDEX;
              end else if (free_over) begin
                push_res.status = STS_OVERFREE;
              end else begin
                ring_we  = 1'b1;
                tail_nxt = ptr_next(tail_r);
                free_nxt = free_r + 1'b1;
                used_nxt = (used_r != '0) ? used_r - 1'b1 : used_r;
              end
            end
            K_LOOKUP: begin
              priority if (!ready_r) begin
                push = 1'b1;
                push_res.status = STS_NOT_INIT;
                push_res.slot   = cmd.idx[SLOT_W-1:0];
              end else if (!cmd.idx_ok) begin
                push = 1'b1;
                push_res.status = STS_BAD_INDEX;
                push_res.slot   = cmd.idx[SLOT_W-1:0];
              end else begin
                slot_nxt  = cmd.idx[ENTRY_W-1:0];
                look_nxt  = 1'b1;
                state_nxt = ST_MUL;
              end
            end
            default: begin
              push = 1'b1;
            end
          endcase
          push_res.in_use = used_nxt;
        end
      end
      ST_FILL: begin
        ring_we    = 1'b1;
        ring_waddr = fill_r;
        ring_wdata = ENTRY_W'(fill_r);
        if (fill_last) begin
          push      = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          fill_nxt = fill_r + 1'b1;
        end
      end
      ST_MUL: begin
        slot_nxt  = mul_in;
        prod_nxt  = PROD_W'(mul_in) * PROD_W'(cfg.slot_stride);
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        push              = 1'b1;
        push_res.slot     = slot_r[SLOT_W-1:0];
        push_res.cpu_addr = cfg.cpu_base + ADDR_W'(prod_r);
        push_res.gpu_addr = vis_r ? cfg.gpu_base + ADDR_W'(prod_r) : '0;
        state_nxt         = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      free_r  <= '0;
      used_r  <= '0;
      ready_r <= 1'b0;
      vis_r   <= 1'b0;
      q_cnt_r <= 2'd0;
      q_wp_r  <= 1'b0;
      q_rp_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      free_r  <= free_nxt;
      used_r  <= used_nxt;
      ready_r <= ready_nxt;
      vis_r   <= vis_nxt;
      q_cnt_r <= q_cnt_r + {1'b0, push} - {1'b0, pop};
      q_wp_r  <= push ? ~q_wp_r : q_wp_r;
      q_rp_r  <= pop ? ~q_rp_r : q_rp_r;
    end
  end

  always_ff @(posedge clk) begin
    fill_r <= fill_nxt;
    slot_r <= slot_nxt;
    look_r <= look_nxt;
    prod_r <= prod_nxt;
    if (push) begin
      q_mem[q_wp_r] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= ring_wdata;
    end
    ring_rdata_r <= ring_mem[head_r];
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import fia_pkg::*;

  localparam int RING_DEPTH = 1024;
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 150;
  localparam int LONG_HOLD = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 20;
  localparam logic [ADDR_W-1:0] ALL_ONES = {ADDR_W{1'b1}};

  logic                 clk;
  logic                 rst_n;
  logic                 in_push;
  logic                 in_full;
  logic [2:0]           in_op;
  logic [IDX_W-1:0]     in_slot_index;
  logic                 in_handle_valid;
  logic                 out_empty;
  logic                 out_pop;
  logic [2:0]           out_status;
  logic [SLOT_W-1:0]    out_slot_out;
  logic [ADDR_W-1:0]    out_cpu_addr;
  logic [ADDR_W-1:0]    out_gpu_addr;
  logic [CNT_W-1:0]     out_in_use;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_data;

  fifo_index_allocator_core #(.MAX_SLOTS(RING_DEPTH)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_op           (in_op),
    .in_slot_index   (in_slot_index),
    .in_handle_valid (in_handle_valid),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_status      (out_status),
    .out_slot_out    (out_slot_out),
    .out_cpu_addr    (out_cpu_addr),
    .out_gpu_addr    (out_gpu_addr),
    .out_in_use      (out_in_use),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  typedef struct {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] reg_sel;
    logic [ADDR_W-1:0]    reg_val;
    logic [2:0]           op;
    logic [IDX_W-1:0]     idx;
    logic                 hv;
    logic                 typed;
    res_t                 want;
  } stim_row_t;

  stim_row_t         stim_table[$];
  res_t              pending_responses[$];
  logic [SLOT_W-1:0] granted_slots[$];

  logic [CNT_W-1:0]    cap_reg = '0;
  logic [STRIDE_W-1:0] stride_reg = 16'd32;
  logic [ADDR_W-1:0]   cpu_base_reg = '0;
  logic [ADDR_W-1:0]   gpu_base_reg = '0;
  logic [1:0]          kind_reg = '0;
  logic                vis_req_reg = 1'b0;

  logic [IDX_W-1:0] free_slots [RING_DEPTH];
  int               free_rd = 0;
  int               free_wr = 0;
  int               free_total = 0;
  int               busy_total = 0;
  logic             is_ready = 1'b0;
  logic             is_visible = 1'b0;

  int   errors = 0;
  int   cycle_count = 0;
  int   send_idle = 0;
  int   rcv_idle = 0;
  logic long_hold_req = 1'b0;
  logic long_hold_done = 1'b0;
  res_t head_resp;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [ADDR_W-1:0] base,
                                                  input logic [IDX_W-1:0] s);
    return base + {48'd0, s} * {48'd0, stride_reg};
  endfunction

  function automatic int ring_step(input int p);
    return (p + 1 >= RING_DEPTH) ? 0 : p + 1;
  endfunction

  task automatic derive_response(input logic [2:0] op, input logic [IDX_W-1:0] idx,
                                 input logic hv, output res_t r);
    logic [IDX_W-1:0] s;
    int               i;
    r = '0;
    case (op)
      OP_INIT: begin
        if (!is_ready) begin
          if (cap_reg == 0 || cap_reg > RING_DEPTH) begin
            r.status = STS_BAD_CAP;
          end else begin
            is_visible = vis_req_reg && (kind_reg < 2);
            for (i = 0; i < cap_reg; i++) free_slots[i] = IDX_W'(i);
            free_rd = 0;
            free_wr = (cap_reg >= RING_DEPTH) ? 0 : int'(cap_reg);
            free_total = int'(cap_reg);
            busy_total = 0;
            is_ready = 1'b1;
          end
        end
      end
      OP_ALLOCATE: begin
        if (!is_ready) begin
          r.status = STS_NOT_INIT;
        end else if (free_total == 0) begin
          r.status = STS_FULL;
        end else begin
          s = free_slots[free_rd];
          free_rd = ring_step(free_rd);
          free_total--;
          busy_total++;
          r.slot = s[SLOT_W-1:0];
          r.cpu_addr = slot_addr(cpu_base_reg, s);
          r.gpu_addr = is_visible ? slot_addr(gpu_base_reg, s) : '0;
          granted_slots.push_back(s[SLOT_W-1:0]);
        end
      end
      OP_FREE: begin
        r.slot = idx[SLOT_W-1:0];
        if (!is_ready) begin
          r.status = STS_NOT_INIT;
        end else if (!hv || idx >= cap_reg) begin
          r.status = STS_BAD_INDEX;
        end else if (free_total >= cap_reg || free_total >= RING_DEPTH) begin
          r.status = STS_OVERFREE;
        end else begin
          free_slots[free_wr] = idx;
          free_wr = ring_step(free_wr);
          free_total++;
          if (busy_total > 0) busy_total--;
        end
      end
      OP_CPU_LOOKUP, OP_GPU_LOOKUP: begin
        r.slot = idx[SLOT_W-1:0];
        if (!is_ready) begin
          r.status = STS_NOT_INIT;
        end else if (idx >= cap_reg) begin
          r.status = STS_BAD_INDEX;
        end else begin
          r.cpu_addr = slot_addr(cpu_base_reg, idx);
          r.gpu_addr = is_visible ? slot_addr(gpu_base_reg, idx) : '0;
        end
      end
      default: begin
      end
    endcase
    r.in_use = busy_total[CNT_W-1:0];
  endtask

  task automatic apply_cfg(input logic [CFG_IDX_W-1:0] sel, input logic [ADDR_W-1:0] val);
    case (sel)
      CFG_CAPACITY:     cap_reg = val[CNT_W-1:0];
      CFG_SLOT_STRIDE:  stride_reg = val[STRIDE_W-1:0];
      CFG_CPU_BASE:     cpu_base_reg = val;
      CFG_GPU_BASE:     gpu_base_reg = val;
      CFG_HEAP_KIND:    kind_reg = val[1:0];
      CFG_WANT_VISIBLE: vis_req_reg = val[0];
      default: begin
      end
    endcase
  endtask

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] sel,
                                  input logic [ADDR_W-1:0] val);
    stim_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.reg_sel = sel;
    row.reg_val = val;
    stim_table.push_back(row);
  endfunction

  function automatic void add_op(input logic [2:0] op, input logic [IDX_W-1:0] idx,
                                 input logic hv);
    stim_row_t row;
    row = '{default: '0};
    row.op = op;
    row.idx = idx;
    row.hv = hv;
    stim_table.push_back(row);
  endfunction

  function automatic void add_op_exp(input logic [2:0] op, input logic [IDX_W-1:0] idx,
                                     input logic hv, input status_t st,
                                     input logic [SLOT_W-1:0] sl,
                                     input logic [ADDR_W-1:0] ca,
                                     input logic [ADDR_W-1:0] ga,
                                     input logic [CNT_W-1:0] used);
    stim_row_t row;
    row = '{default: '0};
    row.op = op;
    row.idx = idx;
    row.hv = hv;
    row.typed = 1'b1;
    row.want.status = st;
    row.want.slot = sl;
    row.want.cpu_addr = ca;
    row.want.gpu_addr = ga;
    row.want.in_use = used;
    stim_table.push_back(row);
  endfunction

  task automatic check_field(input string name, input logic [ADDR_W-1:0] exp,
                             input logic [ADDR_W-1:0] got);
    if (exp !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp, got);
      errors++;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_push <= 1'b0;
    while (pending_responses.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] sel, input logic [ADDR_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_cfg(sel, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(input logic [2:0] op, input logic [IDX_W-1:0] idx,
                           input logic hv, input logic typed, input res_t want);
    res_t r;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_op <= op;
    in_slot_index <= idx;
    in_handle_valid <= hv;
    do @(posedge clk); while (in_full);
    derive_response(op, idx, hv, r);
    pending_responses.push_back(typed ? want : r);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL fifo_index_allocator_core");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pending_responses.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got status %h slot %h", $time,
                 out_status, out_slot_out);
        errors++;
      end else begin
        head_resp = pending_responses.pop_front();
        check_field("status", ADDR_W'(head_resp.status), ADDR_W'(out_status));
        check_field("slot_out", ADDR_W'(head_resp.slot), ADDR_W'(out_slot_out));
        check_field("cpu_addr", head_resp.cpu_addr, out_cpu_addr);
        check_field("gpu_addr", head_resp.gpu_addr, out_gpu_addr);
        check_field("in_use", ADDR_W'(head_resp.in_use), ADDR_W'(out_in_use));
      end
    end
  end

  initial begin
    out_pop = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        out_pop <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      out_pop <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  initial begin
    int               p;
    int               k;
    int               pick;
    int               sel;
    logic [2:0]       op;
    logic [IDX_W-1:0] idx;
    logic             hv;
    logic [CNT_W-1:0] cap_pick;
    logic [ADDR_W-1:0] cpu_pick;
    logic [ADDR_W-1:0] gpu_pick;
    logic [STRIDE_W-1:0] stride_pick;

    rst_n = 1'b0;
    in_push = 1'b0;
    in_op = OP_INIT;
    in_slot_index = '0;
    in_handle_valid = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_CAPACITY;
    cfg_data = '0;
    send_idle = 6;
    rcv_idle = 74;

    add_op_exp(OP_ALLOCATE, 16'd0, 1'b1, STS_NOT_INIT, '0, '0, '0, '0);
    add_op_exp(OP_FREE, 16'd5, 1'b1, STS_NOT_INIT, 10'd5, '0, '0, '0);
    add_op_exp(OP_CPU_LOOKUP, 16'hFFFF, 1'b0, STS_NOT_INIT, 10'd1023, '0, '0, '0);
    add_op_exp(OP_GPU_LOOKUP, 16'd0, 1'b0, STS_NOT_INIT, '0, '0, '0, '0);
    add_op_exp(OP_SPARE_LO, 16'd7, 1'b1, STS_OK, '0, '0, '0, '0);
    add_op_exp(OP_SPARE_HI, 16'hFFFF, 1'b1, STS_OK, '0, '0, '0, '0);
    add_op_exp(OP_INIT, 16'd0, 1'b0, STS_BAD_CAP, '0, '0, '0, '0);
    add_cfg(CFG_CAPACITY, 64'd1500);
    add_op_exp(OP_INIT, 16'd0, 1'b0, STS_BAD_CAP, '0, '0, '0, '0);
    add_cfg(CFG_CAPACITY, 64'd4);
    add_cfg(CFG_SLOT_STRIDE, 64'd65535);
    add_cfg(CFG_CPU_BASE, ALL_ONES);
    add_cfg(CFG_GPU_BASE, '0);
    add_cfg(CFG_HEAP_KIND, ADDR_W'($urandom_range(0, 3)));
    add_cfg(CFG_WANT_VISIBLE, 64'd1);
    add_op_exp(OP_INIT, 16'd0, 1'b0, STS_OK, '0, '0, '0, '0);
    add_op_exp(OP_INIT, 16'd0, 1'b0, STS_OK, '0, '0, '0, '0);
    add_op_exp(OP_ALLOCATE, 16'd0, 1'b0, STS_OK, '0, ALL_ONES, '0, 11'd1);
    add_op(OP_ALLOCATE, 16'd0, 1'b0);
    add_op(OP_ALLOCATE, 16'd0, 1'b0);
    add_op(OP_ALLOCATE, 16'd0, 1'b0);
    add_op_exp(OP_ALLOCATE, 16'd0, 1'b0, STS_FULL, '0, '0, '0, 11'd4);
    add_op_exp(OP_FREE, 16'd4, 1'b1, STS_BAD_INDEX, 10'd4, '0, '0, 11'd4);
    add_op_exp(OP_FREE, 16'd1, 1'b0, STS_BAD_INDEX, 10'd1, '0, '0, 11'd4);
    add_op_exp(OP_FREE, 16'd2, 1'b1, STS_OK, 10'd2, '0, '0, 11'd3);
    add_op_exp(OP_FREE, 16'd0, 1'b1, STS_OK, 10'd0, '0, '0, 11'd2);
    add_op_exp(OP_FREE, 16'd1, 1'b1, STS_OK, 10'd1, '0, '0, 11'd1);
    add_op_exp(OP_FREE, 16'd3, 1'b1, STS_OK, 10'd3, '0, '0, 11'd0);
    add_op_exp(OP_FREE, 16'd2, 1'b1, STS_OVERFREE, 10'd2, '0, '0, 11'd0);
    add_op(OP_CPU_LOOKUP, 16'd3, 1'b0);
    add_op_exp(OP_GPU_LOOKUP, 16'hFFFF, 1'b1, STS_BAD_INDEX, 10'd1023, '0, '0, 11'd0);
    add_op(OP_ALLOCATE, 16'd0, 1'b1);

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[n]) begin
      if (stim_table[n].is_cfg) begin
        wait_drained();
        cfg_write(stim_table[n].reg_sel, stim_table[n].reg_val);
      end else begin
        send_item(stim_table[n].op, stim_table[n].idx, stim_table[n].hv,
                  stim_table[n].typed, stim_table[n].want);
      end
    end

    for (p = 0; p < PHASES; p++) begin
      wait_drained();
      if (p < 3) begin
        send_idle = 6;
        rcv_idle = 74;
      end else if (p < 6) begin
        send_idle = 74;
        rcv_idle = 6;
      end else begin
        send_idle = 0;
        rcv_idle = 0;
      end
      case (p)
        0: cap_pick = 11'd1024;
        1: cap_pick = 11'd1;
        2: cap_pick = 11'd0;
        3: cap_pick = CNT_W'($urandom_range(2, 32));
        4: cap_pick = 11'd1024;
        5: cap_pick = CNT_W'($urandom_range(1, 1024));
        6: cap_pick = CNT_W'($urandom_range(2, 16));
        default: cap_pick = 11'd1024;
      endcase
      stride_pick = (p == 0) ? 16'd0 : (p == 1) ? 16'hFFFF : (p == 2) ? 16'd32 :
                    16'($urandom_range(0, 65535));
      cpu_pick = (p == 1) ? ALL_ONES : (p == 2) ? '0 : {$urandom, $urandom};
      gpu_pick = (p == 1) ? ALL_ONES : (p == 0) ? '0 : {$urandom, $urandom};
      cfg_write(CFG_CAPACITY, {53'd0, cap_pick});
      cfg_write(CFG_SLOT_STRIDE, {48'd0, stride_pick});
      cfg_write(CFG_CPU_BASE, cpu_pick);
      cfg_write(CFG_GPU_BASE, gpu_pick);
      cfg_write(CFG_HEAP_KIND, ADDR_W'($urandom_range(0, 3)));
      cfg_write(CFG_WANT_VISIBLE, ADDR_W'($urandom_range(0, 1)));
      if (p == 6) long_hold_req = 1'b1;

      for (k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        idx = IDX_W'($urandom_range(0, 65535));
        hv = 1'($urandom_range(0, 1));
        if (pick < 34) begin
          op = OP_ALLOCATE;
        end else if (pick < 64 && granted_slots.size() != 0) begin
          sel = $urandom_range(0, granted_slots.size() - 1);
          op = OP_FREE;
          idx = {6'd0, granted_slots[sel]};
          hv = 1'b1;
          granted_slots.delete(sel);
        end else if (pick < 74) begin
          op = OP_FREE;
          if (pick[0]) idx = IDX_W'($urandom_range(0, cap_reg));
        end else if (pick < 94) begin
          op = pick[0] ? OP_CPU_LOOKUP : OP_GPU_LOOKUP;
          if (pick % 5 != 0) idx = IDX_W'($urandom_range(0, cap_reg));
        end else if (pick < 97) begin
          op = OP_INIT;
        end else begin
          op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        end
        send_item(op, idx, hv, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("PASS fifo_index_allocator_core");
    end else begin
      $display("FAIL fifo_index_allocator_core");
    end
    $finish;
  end

endmodule
